FILE: rtl/etf_pkg.sv
package etf_pkg;

    localparam int COORD_W = 10;
    localparam int ZOOM_W = 31;
    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int COUNT_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 31'h1000_0000;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd100;

    localparam logic MODE_MANDELBROT = 1'b0;
    localparam logic MODE_JULIA = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRACTAL_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZOOM_SCALE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_OFFSET_REAL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_OFFSET_IMAG = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_JULIA_CONST_REAL = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_JULIA_CONST_IMAG = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_ITERATION_LIMIT = 3'd6;

    typedef struct packed {
        logic                       fractal_mode;
        logic [ZOOM_W-1:0]          zoom_scale;
        logic signed [DATA_W-1:0]   view_offset_real;
        logic signed [DATA_W-1:0]   view_offset_imag;
        logic signed [DATA_W-1:0]   julia_const_real;
        logic signed [DATA_W-1:0]   julia_const_imag;
        logic [COUNT_W-1:0]         iteration_limit;
    } cfg_t;

    // One mapped pixel: its coordinates and the start of its orbit.
    typedef struct packed {
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
        logic signed [DATA_W-1:0]   z_re;
        logic signed [DATA_W-1:0]   z_im;
        logic signed [DATA_W-1:0]   c_re;
        logic signed [DATA_W-1:0]   c_im;
    } entry_t;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
        if (v > PROD_W'(DATA_MAX))
            return DATA_MAX;
        if (v < PROD_W'(DATA_MIN))
            return DATA_MIN;
        return v[DATA_W-1:0];
    endfunction

endpackage

FILE: rtl/etf_axis_map.sv
module etf_axis_map #(
    parameter int SIZE = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [etf_pkg::COORD_W-1:0]         coord,
    input  logic [etf_pkg::ZOOM_W-1:0]          zoom,
    input  logic signed [etf_pkg::DATA_W-1:0]   offset,
    output logic                                idle,
    output logic signed [etf_pkg::DATA_W-1:0]   point
);

    localparam int LOG_SIZE = $clog2(SIZE);
    localparam int DW = (etf_pkg::COORD_W > LOG_SIZE) ? etf_pkg::COORD_W : LOG_SIZE;
    localparam int PW = DW + etf_pkg::ZOOM_W;
    localparam int SW = PW + 2;
    // The divide by the image size is a multiply by the reciprocal rounded up to
    // SH fraction bits, which is exact for every product below 2^PW.
    localparam int SH = PW + LOG_SIZE;
    localparam int CHUNK_W = 16;
    localparam int RCP_W = PW + 1;
    localparam int NCHUNK = (RCP_W + CHUNK_W - 1) / CHUNK_W;
    localparam int RCP_PAD_W = NCHUNK * CHUNK_W;
    localparam int ACC_W = PW + RCP_PAD_W;
    localparam int PART_W = PW + CHUNK_W;
    localparam int CNW = $clog2(NCHUNK + 1);
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(SIZE) - 64'd1) / 64'(SIZE);
    localparam logic signed [DW:0] HALF = (DW + 1)'(SIZE / 2);

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_DIV,
        M_SIGN,
        M_SUM
    } map_state_t;

    map_state_t               state_reg;
    logic                     neg_reg;
    logic [DW-1:0]            magd_reg;
    logic [PW-1:0]            dvd_reg;
    logic [RCP_PAD_W-1:0]     rcp_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [CNW-1:0]           cnt_reg;
    logic signed [PW:0]       q_reg;
    logic signed [DW:0]       diff;
    logic [DW-1:0]            diff_mag;
    logic [PW-1:0]            prod;
    logic [PART_W-1:0]        partial;
    logic [PW-1:0]            quot;
    logic signed [SW-1:0]     sum;

    assign diff = $signed({1'b0, DW'(coord)}) - HALF;
    assign diff_mag = diff[DW] ? DW'(-diff) : diff[DW-1:0];
    assign prod = PW'(magd_reg) * PW'(zoom);

    // One 16-bit slice of the reciprocal per cycle, most significant slice first.
    assign partial = PART_W'(dvd_reg) * PART_W'(rcp_reg[RCP_PAD_W-1 -: CHUNK_W]);
    assign quot = PW'(acc_reg >> SH);

    assign sum = SW'(q_reg) + SW'(offset);

    assign idle = (state_reg == M_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                        state_reg <= M_MUL;
                end
                M_MUL:
                begin
                    cnt_reg <= CNW'(NCHUNK);
                    state_reg <= M_DIV;
                end
                M_DIV:
                begin
                    cnt_reg <= cnt_reg - CNW'(1);
                    if (cnt_reg == CNW'(1))
                        state_reg <= M_SIGN;
                end
                M_SIGN:
                begin
                    state_reg <= M_SUM;
                end
                M_SUM:
                begin
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    neg_reg <= diff[DW];
                    magd_reg <= diff_mag;
                end
            end
            M_MUL:
            begin
                dvd_reg <= prod;
                rcp_reg <= RCP_PAD_W'(RECIP);
                acc_reg <= '0;
            end
            M_DIV:
            begin
                acc_reg <= (acc_reg << CHUNK_W) + ACC_W'(partial);
                rcp_reg <= rcp_reg << CHUNK_W;
            end
            M_SIGN:
            begin
                // The magnitude was divided, so the quotient truncates toward zero.
                q_reg <= neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
            end
            M_SUM:
            begin
                if (sum > SW'(etf_pkg::DATA_MAX))
                    point <= etf_pkg::DATA_MAX;
                else if (sum < SW'(etf_pkg::DATA_MIN))
                    point <= etf_pkg::DATA_MIN;
                else
                    point <= sum[etf_pkg::DATA_W-1:0];
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

endmodule

FILE: rtl/etf_front.sv
module etf_front #(
    parameter int IMAGE_WIDTH = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  etf_pkg::cfg_t                   cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [etf_pkg::COORD_W-1:0]     pixel_col,
    input  logic [etf_pkg::COORD_W-1:0]     pixel_row,
    output logic                            push_valid,
    input  logic                            push_ready,
    output etf_pkg::entry_t                 push_data
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MAP,
        F_PUSH
    } front_state_t;

    front_state_t                       state_reg;
    logic [etf_pkg::COORD_W-1:0]        col_reg;
    logic [etf_pkg::COORD_W-1:0]        row_reg;
    etf_pkg::entry_t                    entry_reg;
    logic                               start;
    logic                               col_idle;
    logic                               row_idle;
    logic signed [etf_pkg::DATA_W-1:0]  point_re;
    logic signed [etf_pkg::DATA_W-1:0]  point_im;

    assign in_ready = (state_reg == F_IDLE);
    assign start = in_valid && in_ready;
    assign push_valid = (state_reg == F_PUSH);
    assign push_data = entry_reg;

    etf_axis_map #(
        .SIZE(IMAGE_WIDTH)
    ) u_map_re (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .coord(pixel_col),
        .zoom(cfg.zoom_scale),
        .offset(cfg.view_offset_real),
        .idle(col_idle),
        .point(point_re)
    );

    etf_axis_map #(
        .SIZE(IMAGE_HEIGHT)
    ) u_map_im (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .coord(pixel_row),
        .zoom(cfg.zoom_scale),
        .offset(cfg.view_offset_imag),
        .idle(row_idle),
        .point(point_im)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (start)
                        state_reg <= F_MAP;
                end
                F_MAP:
                begin
                    if (col_idle && row_idle)
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (push_ready)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            col_reg <= pixel_col;
            row_reg <= pixel_row;
        end
        if (state_reg == F_MAP && col_idle && row_idle)
        begin
            entry_reg.col <= col_reg;
            entry_reg.row <= row_reg;
            if (cfg.fractal_mode == etf_pkg::MODE_JULIA)
            begin
                entry_reg.z_re <= point_re;
                entry_reg.z_im <= point_im;
                entry_reg.c_re <= cfg.julia_const_real;
                entry_reg.c_im <= cfg.julia_const_imag;
            end
            else
            begin
                entry_reg.z_re <= '0;
                entry_reg.z_im <= '0;
                entry_reg.c_re <= point_re;
                entry_reg.c_im <= point_im;
            end
        end
    end

endmodule

FILE: rtl/etf_queue.sv
module etf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  etf_pkg::entry_t     push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output etf_pkg::entry_t     pop_data
);

    // Depth is a power of two so the pointers wrap on their own.
    localparam int PTR_W = $clog2(etf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(etf_pkg::QUEUE_DEPTH + 1);

    etf_pkg::entry_t        mem_reg [etf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != CNT_W'(etf_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/etf_back.sv
module etf_back #(
    parameter int FRACTION_BITS = 28
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [etf_pkg::COUNT_W-1:0]     iteration_limit,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  etf_pkg::entry_t                 pop_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [etf_pkg::COORD_W-1:0]     out_col,
    output logic [etf_pkg::COORD_W-1:0]     out_row,
    output logic [etf_pkg::COUNT_W-1:0]     iteration_count,
    output logic                            escaped
);

    localparam int PW = etf_pkg::PROD_W;
    localparam logic [PW-1:0] FOUR = PW'(4) << FRACTION_BITS;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_EVAL,
        B_DONE
    } back_state_t;

    back_state_t                        state_reg;
    logic                               out_valid_reg;
    logic [etf_pkg::COORD_W-1:0]        col_reg;
    logic [etf_pkg::COORD_W-1:0]        row_reg;
    logic signed [etf_pkg::DATA_W-1:0]  z_re_reg;
    logic signed [etf_pkg::DATA_W-1:0]  z_im_reg;
    logic signed [etf_pkg::DATA_W-1:0]  c_re_reg;
    logic signed [etf_pkg::DATA_W-1:0]  c_im_reg;
    logic [etf_pkg::COUNT_W-1:0]        iter_reg;
    logic                               esc_reg;
    logic signed [PW-1:0]               rr_reg;
    logic signed [PW-1:0]               ii_reg;
    logic signed [PW-1:0]               ri_reg;
    logic signed [PW-1:0]               rr_next;
    logic signed [PW-1:0]               ii_next;
    logic signed [PW-1:0]               ri_next;
    logic [PW-1:0]                      mag;
    logic                               outside;
    logic                               at_limit;
    logic signed [PW-1:0]               diff_w;
    logic signed [PW-1:0]               re_w;
    logic signed [PW-1:0]               im_w;
    logic                               slot_free;

    assign pop_ready = (state_reg == B_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    assign rr_next = PW'(z_re_reg) * PW'(z_re_reg);
    assign ii_next = PW'(z_im_reg) * PW'(z_im_reg);
    assign ri_next = PW'(z_re_reg) * PW'(z_im_reg);

    // Both squares are non-negative, so a logical shift floors them.
    assign mag = ($unsigned(rr_reg) >> FRACTION_BITS) + ($unsigned(ii_reg) >> FRACTION_BITS);
    assign outside = (mag >= FOUR);
    assign at_limit = (iter_reg >= iteration_limit);

    // The imaginary part takes 2*re*im, folded into a shift one bit shorter.
    assign diff_w = rr_reg - ii_reg;
    assign re_w = (diff_w >>> FRACTION_BITS) + PW'(c_re_reg);
    assign im_w = (ri_reg >>> (FRACTION_BITS - 1)) + PW'(c_im_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            out_valid_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            // A result leaving while the next one is loaded keeps valid high.
            if (out_valid_reg && out_ready && state_reg != B_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        iter_reg <= '0;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    state_reg <= B_EVAL;
                end
                B_EVAL:
                begin
                    if (outside || at_limit)
                        state_reg <= B_DONE;
                    else
                    begin
                        iter_reg <= iter_reg + etf_pkg::COUNT_W'(1);
                        state_reg <= B_MUL;
                    end
                end
                B_DONE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    col_reg <= pop_data.col;
                    row_reg <= pop_data.row;
                    z_re_reg <= pop_data.z_re;
                    z_im_reg <= pop_data.z_im;
                    c_re_reg <= pop_data.c_re;
                    c_im_reg <= pop_data.c_im;
                end
            end
            B_MUL:
            begin
                rr_reg <= rr_next;
                ii_reg <= ii_next;
                ri_reg <= ri_next;
            end
            B_EVAL:
            begin
                // Reaching the limit wins over an escape seen at the same count.
                esc_reg <= outside && !at_limit;
                if (!outside && !at_limit)
                begin
                    z_re_reg <= etf_pkg::sat_data(re_w);
                    z_im_reg <= etf_pkg::sat_data(im_w);
                end
            end
            B_DONE:
            begin
                if (slot_free)
                begin
                    out_col <= col_reg;
                    out_row <= row_reg;
                    iteration_count <= iter_reg;
                    escaped <= esc_reg;
                end
            end
            default:
            begin
                esc_reg <= esc_reg;
            end
        endcase
    end

endmodule

FILE: rtl/escape_time_fractal_iterator.sv
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_write_en          cfg_index, cfg_data
// in        in         in_valid / in_ready   pixel_col, pixel_row
// out       out        out_valid / out_ready out_col, out_row, iteration_count, escaped
//
// The front maps one pixel at a time, taking the next only once the last is pushed: a
// multiply, then the divide by the image size as a reciprocal multiply in three 16-bit
// slices at the default sizes. Each back iteration multiplies on its three 32x32
// multipliers, then runs the escape test; a two-entry queue lets the front map the next
// pixel meanwhile. Reset clears all control state and loads the register defaults.
// Either side stalls alone: a full queue holds the front, a taken output slot the back.
module escape_time_fractal_iterator #(
    parameter int IMAGE_WIDTH = 1024,
    parameter int IMAGE_HEIGHT = 1024,
    parameter int FRACTION_BITS = 28
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [etf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [etf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [etf_pkg::COORD_W-1:0]         pixel_col,
    input  logic [etf_pkg::COORD_W-1:0]         pixel_row,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [etf_pkg::COORD_W-1:0]         out_col,
    output logic [etf_pkg::COORD_W-1:0]         out_row,
    output logic [etf_pkg::COUNT_W-1:0]         iteration_count,
    output logic                                escaped
);

    etf_pkg::cfg_t      cfg_reg;
    etf_pkg::entry_t    push_data;
    etf_pkg::entry_t    pop_data;
    logic               push_valid;
    logic               push_ready;
    logic               pop_valid;
    logic               pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fractal_mode <= etf_pkg::MODE_MANDELBROT;
            cfg_reg.zoom_scale <= etf_pkg::ZOOM_RESET;
            cfg_reg.view_offset_real <= '0;
            cfg_reg.view_offset_imag <= '0;
            cfg_reg.julia_const_real <= '0;
            cfg_reg.julia_const_imag <= '0;
            cfg_reg.iteration_limit <= etf_pkg::LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                etf_pkg::CFG_FRACTAL_MODE:
                    cfg_reg.fractal_mode <= cfg_data[0];
                etf_pkg::CFG_ZOOM_SCALE:
                    cfg_reg.zoom_scale <= cfg_data[etf_pkg::ZOOM_W-1:0];
                etf_pkg::CFG_VIEW_OFFSET_REAL:
                    cfg_reg.view_offset_real <= $signed(cfg_data);
                etf_pkg::CFG_VIEW_OFFSET_IMAG:
                    cfg_reg.view_offset_imag <= $signed(cfg_data);
                etf_pkg::CFG_JULIA_CONST_REAL:
                    cfg_reg.julia_const_real <= $signed(cfg_data);
                etf_pkg::CFG_JULIA_CONST_IMAG:
                    cfg_reg.julia_const_imag <= $signed(cfg_data);
                etf_pkg::CFG_ITERATION_LIMIT:
                    cfg_reg.iteration_limit <= cfg_data[etf_pkg::COUNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    etf_front #(
        .IMAGE_WIDTH(IMAGE_WIDTH),
        .IMAGE_HEIGHT(IMAGE_HEIGHT)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pixel_col(pixel_col),
        .pixel_row(pixel_row),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data(push_data)
    );

    etf_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data(push_data),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data(pop_data)
    );

    etf_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .iteration_limit(cfg_reg.iteration_limit),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data(pop_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_col(out_col),
        .out_row(out_row),
        .iteration_count(iteration_count),
        .escaped(escaped)
    );

endmodule

FILE: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 28;
    localparam int IMG_W = 1024;
    localparam int IMG_H = 1024;
    localparam logic [etf_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef struct packed {
        logic [etf_pkg::COORD_W-1:0] col;
        logic [etf_pkg::COORD_W-1:0] row;
        logic [etf_pkg::COUNT_W-1:0] count;
        logic                        escaped;
    } pixel_result_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_write_en;
    logic [etf_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [etf_pkg::CFG_DATA_W-1:0]      cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic [etf_pkg::COORD_W-1:0]         pixel_col;
    logic [etf_pkg::COORD_W-1:0]         pixel_row;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [etf_pkg::COORD_W-1:0]         out_col;
    logic [etf_pkg::COORD_W-1:0]         out_row;
    logic [etf_pkg::COUNT_W-1:0]         iteration_count;
    logic                                escaped;

    class escape_scoreboard;
        logic                        mode;
        logic [etf_pkg::ZOOM_W-1:0]  zoom;
        int                          off_re;
        int                          off_im;
        int                          jc_re;
        int                          jc_im;
        logic [etf_pkg::COUNT_W-1:0] limit;
        pixel_result_t               expected_pixels[$];
        int                          failures;
        int                          checked;
        int                          escapes;

        function new();
            mode = etf_pkg::MODE_MANDELBROT;
            zoom = etf_pkg::ZOOM_RESET;
            off_re = 0;
            off_im = 0;
            jc_re = 0;
            jc_im = 0;
            limit = etf_pkg::LIMIT_RESET;
            failures = 0;
            checked = 0;
            escapes = 0;
        endfunction

        function void set_register(input logic [etf_pkg::CFG_INDEX_W-1:0] idx,
                                   input logic [etf_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                etf_pkg::CFG_FRACTAL_MODE:     mode = data[0];
                etf_pkg::CFG_ZOOM_SCALE:       zoom = data[etf_pkg::ZOOM_W-1:0];
                etf_pkg::CFG_VIEW_OFFSET_REAL: off_re = data;
                etf_pkg::CFG_VIEW_OFFSET_IMAG: off_im = data;
                etf_pkg::CFG_JULIA_CONST_REAL: jc_re = data;
                etf_pkg::CFG_JULIA_CONST_IMAG: jc_im = data;
                etf_pkg::CFG_ITERATION_LIMIT:  limit = data[etf_pkg::COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int clamp_word(input longint v);
            if (v > longint'(etf_pkg::DATA_MAX))
                return etf_pkg::DATA_MAX;
            if (v < longint'(etf_pkg::DATA_MIN))
                return etf_pkg::DATA_MIN;
            return int'(v);
        endfunction

        // The division truncates toward zero, as the hardware divider does.
        function int place_on_axis(input logic [etf_pkg::COORD_W-1:0] coord,
                                   input longint size, input int offset);
            longint span;
            span = (longint'(coord) - size / 2) * longint'(zoom);
            return clamp_word(span / size + longint'(offset));
        endfunction

        function pixel_result_t predict_escape(input logic [etf_pkg::COORD_W-1:0] col,
                                               input logic [etf_pkg::COORD_W-1:0] row);
            int                          pr;
            int                          pim;
            int                          zr;
            int                          zi;
            int                          cr;
            int                          ci;
            longint                      rr;
            longint                      sq_im;
            longint                      ri;
            logic [etf_pkg::COUNT_W-1:0] count;
            bit                          outside;
            bit                          done;
            pixel_result_t               r;
            pr = place_on_axis(col, IMG_W, off_re);
            pim = place_on_axis(row, IMG_H, off_im);
            if (mode == etf_pkg::MODE_MANDELBROT)
            begin
                cr = pr;
                ci = pim;
                zr = 0;
                zi = 0;
            end
            else
            begin
                cr = jc_re;
                ci = jc_im;
                zr = pr;
                zi = pim;
            end
            count = '0;
            outside = 1'b0;
            done = 1'b0;
            while (!done)
            begin
                rr = longint'(zr) * longint'(zr);
                sq_im = longint'(zi) * longint'(zi);
                ri = longint'(zr) * longint'(zi);
                // The magnitude test runs first, but a point that is outside when the
                // limit is hit still reports no escape, since escaped needs count < limit.
                if ((rr >>> FRAC) + (sq_im >>> FRAC) >= (longint'(4) <<< FRAC))
                begin
                    outside = 1'b1;
                    done = 1'b1;
                end
                else if (count >= limit)
                begin
                    done = 1'b1;
                end
                else
                begin
                    zr = clamp_word(((rr - sq_im) >>> FRAC) + longint'(cr));
                    zi = clamp_word((ri >>> (FRAC - 1)) + longint'(ci));
                    count = count + 1'b1;
                end
            end
            r.col = col;
            r.row = row;
            r.count = count;
            r.escaped = outside && (count < limit);
            return r;
        endfunction

        function void note_pixel(input logic [etf_pkg::COORD_W-1:0] col,
                                 input logic [etf_pkg::COORD_W-1:0] row);
            expected_pixels.push_back(predict_escape(col, row));
        endfunction

        function void compare_field(input string what, input int want, input int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
                failures++;
            end
        endfunction

        function void check_result(input logic [etf_pkg::COORD_W-1:0] col,
                                   input logic [etf_pkg::COORD_W-1:0] row,
                                   input logic [etf_pkg::COUNT_W-1:0] count,
                                   input logic esc);
            pixel_result_t want;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: result for pixel (%0d,%0d) with none outstanding",
                         $time, col, row);
                failures++;
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (want.escaped)
                escapes++;
            compare_field("out_col", want.col, col);
            compare_field("out_row", want.row, row);
            compare_field("iteration_count", want.count, count);
            compare_field("escaped", want.escaped, esc);
        endfunction
    endclass

    escape_scoreboard tracker = new();
    int burst_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int settings = 1;

    escape_time_fractal_iterator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_col       (pixel_col),
        .pixel_row       (pixel_row),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_col         (out_col),
        .out_row         (out_row),
        .iteration_count (iteration_count),
        .escaped         (escaped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver switches between always ready, toggling, coin flips and
    // long stalls, each held for a random stretch of cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_result(out_col, out_row, iteration_count, escaped);
            if (rx_left == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(8, 80);
            end
            else
            begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ~out_ready;
                2: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_register(input logic [etf_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [etf_pkg::CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        tracker.set_register(idx, data);
    endtask

    task automatic send_pixel(input logic [etf_pkg::COORD_W-1:0] col,
                              input logic [etf_pkg::COORD_W-1:0] row);
        int gap;
        in_valid <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_pixel(col, row);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 25);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (tracker.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random_pixel();
        send_pixel(etf_pkg::COORD_W'($urandom_range(0, 1023)),
                   etf_pkg::COORD_W'($urandom_range(0, 1023)));
    endtask

    task automatic configure_phase(input int phase);
        logic jmode;
        jmode = phase[0];
        if (phase == 0)
        begin
            write_register(etf_pkg::CFG_FRACTAL_MODE, $urandom);
            write_register(etf_pkg::CFG_ZOOM_SCALE, $urandom);
            write_register(etf_pkg::CFG_VIEW_OFFSET_REAL, $urandom);
            write_register(etf_pkg::CFG_VIEW_OFFSET_IMAG, $urandom);
            write_register(etf_pkg::CFG_JULIA_CONST_REAL, $urandom);
            write_register(etf_pkg::CFG_JULIA_CONST_IMAG, $urandom);
            write_register(etf_pkg::CFG_ITERATION_LIMIT, $urandom_range(1, 64));
        end
        else
        begin
            write_register(etf_pkg::CFG_FRACTAL_MODE, {31'd0, jmode});
            write_register(etf_pkg::CFG_ZOOM_SCALE,
                           $urandom_range(32'h0100_0000, 32'h4000_0000));
            if (jmode == etf_pkg::MODE_MANDELBROT)
            begin
                // Centers between -1.5 and 0.5 real, +-0.75 imaginary.
                write_register(etf_pkg::CFG_VIEW_OFFSET_REAL,
                               $urandom_range(0, 32'h2000_0000) - 32'h1800_0000);
                write_register(etf_pkg::CFG_VIEW_OFFSET_IMAG,
                               $urandom_range(0, 32'h1800_0000) - 32'h0C00_0000);
            end
            else
            begin
                write_register(etf_pkg::CFG_VIEW_OFFSET_REAL,
                               $urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
                write_register(etf_pkg::CFG_VIEW_OFFSET_IMAG,
                               $urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
                write_register(etf_pkg::CFG_JULIA_CONST_REAL,
                               $urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
                write_register(etf_pkg::CFG_JULIA_CONST_IMAG,
                               $urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
            end
            write_register(etf_pkg::CFG_ITERATION_LIMIT, $urandom_range(8, 256));
        end
    endtask

    initial
    begin
        int phase;
        int k;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel_col = '0;
        pixel_row = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: the view center stays in the set until the limit.
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        drain_block();

        // A zero limit does no iterations; a write past the register list is ignored.
        write_register(etf_pkg::CFG_ITERATION_LIMIT, 32'd0);
        write_register(CFG_UNUSED_INDEX, '1);
        send_pixel(10'd100, 10'd900);
        send_pixel(10'd0, 10'd0);
        drain_block();
        settings++;

        // Widest view pushed to the corners saturates the first pixel's mapped point. With a
        // limit of one the first step lands outside exactly at the limit.
        write_register(etf_pkg::CFG_ITERATION_LIMIT, 32'd1);
        write_register(etf_pkg::CFG_ZOOM_SCALE, 32'hFFFF_FFFF);
        write_register(etf_pkg::CFG_VIEW_OFFSET_REAL, 32'h7FFF_FFFF);
        write_register(etf_pkg::CFG_VIEW_OFFSET_IMAG, 32'h8000_0000);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        drain_block();
        settings++;

        // Julia with a start point already outside, then extreme constants.
        write_register(etf_pkg::CFG_FRACTAL_MODE, 32'hFFFF_FFFF);
        write_register(etf_pkg::CFG_JULIA_CONST_REAL, 32'h7FFF_FFFF);
        write_register(etf_pkg::CFG_JULIA_CONST_IMAG, 32'h8000_0000);
        write_register(etf_pkg::CFG_ITERATION_LIMIT, 32'd5);
        send_pixel(10'd1023, 10'd0);
        drain_block();
        write_register(etf_pkg::CFG_ZOOM_SCALE, 32'h1000_0000);
        write_register(etf_pkg::CFG_VIEW_OFFSET_REAL, 32'd0);
        write_register(etf_pkg::CFG_VIEW_OFFSET_IMAG, 32'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
        drain_block();
        settings++;

        // c = -1 gives a bounded orbit of period two from zero.
        write_register(etf_pkg::CFG_JULIA_CONST_REAL, 32'hF000_0000);
        write_register(etf_pkg::CFG_JULIA_CONST_IMAG, 32'd0);
        write_register(etf_pkg::CFG_ITERATION_LIMIT, 32'd200);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd600, 10'd400);
        drain_block();
        settings++;

        // Largest limit: one pixel that never escapes, two that escape quickly.
        write_register(etf_pkg::CFG_FRACTAL_MODE, {31'd0, etf_pkg::MODE_MANDELBROT});
        write_register(etf_pkg::CFG_ITERATION_LIMIT, 32'h0000_FFFF);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        drain_block();
        settings++;

        for (phase = 0; phase < 8; phase++)
        begin
            configure_phase(phase);
            settings++;
            for (k = 0; k < 92; k++)
                send_random_pixel();
            drain_block();
        end

        repeat (300) @(posedge clk);
        $display("Checked %0d pixels over %0d register settings in both modes.",
                 tracker.checked, settings);
        $display("%0d of them escaped; the rest ran to the iteration limit.",
                 tracker.escapes);
        if (tracker.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
